>>> src/sorted_note_event_scheduler_assert.svh
// Assertion macros for the note event scheduler.
`ifndef SORTED_NOTE_EVENT_SCHEDULER_ASSERT_SVH
`define SORTED_NOTE_EVENT_SCHEDULER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SNES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("note event scheduler check failed");

// Condition that must never be seen outside reset.
`define SNES_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("note event scheduler check failed");

`endif

>>> src/snes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note event scheduler package
// Shared constants, event codes and the command record between front and back.
// ----------------------------------------------------------------------------
package snes_pkg;

    localparam int MAX_NOTES = 32;
    localparam int IDX_W     = $clog2(MAX_NOTES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MAX_RES   = 64;
    localparam int RES_W     = $clog2(MAX_RES) + 1;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_REM  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [2:0] KIND_ADD_OK  = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_REM     = 3'd2;
    localparam logic [2:0] KIND_ON      = 3'd3;
    localparam logic [2:0] KIND_OFF     = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_REM  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] start;
        logic [31:0] len;
        logic [6:0]  key;
        logic [6:0]  vel;
        logic [31:0] a0;
        logic [31:0] b0;
        logic [31:0] b1;
        logic        wrap;
    } t_cmd;

endpackage

>>> src/snes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note event scheduler front end
// Accepts commands, holds the loop length, works out the scan window parts
// and queues the classified commands for the back end.
// ----------------------------------------------------------------------------
module snes_front import snes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_start_tick,
    input  logic [31:0] i_length_ticks,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_window_from,
    input  logic [31:0] i_window_to,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  logic        i_q_pop
);

    logic [31:0] r_loop;
    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_cmd        n_cmd;
    logic        n_push;
    logic        n_pop;

    always_comb begin
        n_cmd.start = i_start_tick;
        n_cmd.len   = i_length_ticks;
        n_cmd.key   = i_note_number;
        n_cmd.vel   = i_velocity;
        n_cmd.wrap  = (r_loop != 32'd0) && (i_window_from > i_window_to);
        n_cmd.a0    = i_window_from;
        n_cmd.b0    = n_cmd.wrap ? r_loop : i_window_to;
        n_cmd.b1    = i_window_to;
        unique case (i_func)
            FUNC_ADD: n_cmd.op = OP_ADD;
            FUNC_REM: n_cmd.op = OP_REM;
            default:  n_cmd.op = OP_TICK;
        endcase
    end

    assign busy      = (r_cnt == 2'd2);
    assign n_push    = start && !busy && (i_func != FUNC_NOP);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];
    assign n_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop <= 32'd0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_loop <= i_cfg_wdata;
            end
            if (n_push) begin
                r_wp <= ~r_wp;
            end
            if (n_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

>>> src/snes_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note event scheduler back end
// Keeps the sorted note table, walked one entry per step for insert and remove
// (scans take an on and an off step per entry); one result beat per cycle max.
// ----------------------------------------------------------------------------
module snes_back import snes_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_strobe,
    output logic [2:0] o_event_kind,
    output logic [6:0] o_event_note,
    output logic [6:0] o_event_velocity,
    output logic [5:0] o_stored_notes,
    output logic       o_last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_REM   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state       r_state;
    t_cmd         r_cmd;
    logic [31:0]  r_start [MAX_NOTES];
    logic [31:0]  r_len   [MAX_NOTES];
    logic [13:0]  r_kv    [MAX_NOTES];
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_w;
    logic         r_part;
    logic         r_ph;
    logic [RES_W-1:0] r_cnt;
    logic         r_pv;
    logic [2:0]   r_pkind;
    logic [6:0]   r_pnote;
    logic [6:0]   r_pvel;
    logic         r_ostb;
    logic [2:0]   r_okind;
    logic [6:0]   r_onote;
    logic [6:0]   r_ovel;
    logic [5:0]   r_ototal;
    logic         r_olast;

    logic [31:0]  n_s;
    logic [31:0]  n_l;
    logic [13:0]  n_kv;
    logic [31:0]  n_off;
    logic [31:0]  n_a;
    logic [31:0]  n_b;
    logic         n_in;
    logic         n_hit;
    logic [2:0]   n_kind;
    logic [6:0]   n_vel;

    assign n_s   = r_start[r_idx[IDX_W-1:0]];
    assign n_l   = r_len[r_idx[IDX_W-1:0]];
    assign n_kv  = r_kv[r_idx[IDX_W-1:0]];
    assign n_off = n_s + n_l;
    assign n_a   = r_part ? 32'd0 : r_cmd.a0;
    assign n_b   = r_part ? r_cmd.b1 : r_cmd.b0;
    assign n_in  = (r_idx < r_total) && (n_s < n_b);

    always_comb begin
        if (!r_ph) begin
            n_hit  = n_s >= n_a;
            n_kind = KIND_ON;
            n_vel  = n_kv[6:0];
        end else begin
            n_hit  = (n_l != 32'd0) && (n_off >= n_a) && (n_off < n_b);
            n_kind = KIND_OFF;
            n_vel  = 7'd0;
        end
    end

    assign o_q_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_strobe         = r_ostb;
    assign o_event_kind     = r_okind;
    assign o_event_note     = r_onote;
    assign o_event_velocity = r_ovel;
    assign o_stored_notes   = r_ototal;
    assign o_last           = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_idx   <= '0;
            r_w     <= '0;
            r_part  <= 1'b0;
            r_ph    <= 1'b0;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_ostb  <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_ostb <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        r_idx <= '0;
                        r_w   <= '0;
                        r_part <= 1'b0;
                        r_ph  <= 1'b0;
                        r_cnt <= '0;
                        r_pv  <= 1'b0;
                        unique case (i_q_cmd.op)
                            OP_ADD: begin
                                if (r_total >= CNT_W'(MAX_NOTES)) begin
                                    r_ostb   <= 1'b1;
                                    r_okind  <= KIND_FULL;
                                    r_onote  <= 7'd0;
                                    r_ovel   <= 7'd0;
                                    r_ototal <= 6'(r_total);
                                    r_olast  <= 1'b1;
                                end else begin
                                    r_state <= S_ADD;
                                end
                            end
                            OP_REM: r_state <= S_REM;
                            default: begin
                                if (r_total != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if ((r_idx < r_total) && (n_s <= r_cmd.start)) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_total  <= r_total + 1'b1;
                        r_ostb   <= 1'b1;
                        r_okind  <= KIND_ADD_OK;
                        r_onote  <= 7'd0;
                        r_ovel   <= 7'd0;
                        r_ototal <= 6'(r_total + 1'b1);
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_REM: begin
                    if (r_idx < r_total) begin
                        if (!((n_s == r_cmd.start) && (n_kv[13:7] == r_cmd.key))) begin
                            r_w <= r_w + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_total  <= r_w;
                        r_ostb   <= 1'b1;
                        r_okind  <= KIND_REM;
                        r_onote  <= 7'd0;
                        r_ovel   <= 7'd0;
                        r_ototal <= 6'(r_w);
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!n_in) begin
                        r_ph  <= 1'b0;
                        r_idx <= '0;
                        if (r_cmd.wrap && !r_part) begin
                            r_part <= 1'b1;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else begin
                        r_ph <= ~r_ph;
                        if (r_ph) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        if (n_hit && (r_cnt < RES_W'(MAX_RES))) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (r_pv) begin
                                r_ostb   <= 1'b1;
                                r_okind  <= r_pkind;
                                r_onote  <= r_pnote;
                                r_ovel   <= r_pvel;
                                r_ototal <= 6'(r_total);
                                r_olast  <= 1'b0;
                            end
                            r_pv    <= 1'b1;
                            r_pkind <= n_kind;
                            r_pnote <= n_kv[13:7];
                            r_pvel  <= n_vel;
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_pv) begin
                        r_ostb   <= 1'b1;
                        r_okind  <= r_pkind;
                        r_onote  <= r_pnote;
                        r_ovel   <= r_pvel;
                        r_ototal <= 6'(r_total);
                        r_olast  <= 1'b1;
                    end
                    r_pv    <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_ADD) &&
            !((r_idx < r_total) && (n_s <= r_cmd.start))) begin
            for (int j = 1; j < MAX_NOTES; j++) begin
                if ((CNT_W'(j) > r_idx) && (CNT_W'(j) <= r_total)) begin
                    r_start[IDX_W'(j)] <= r_start[IDX_W'(j - 1)];
                    r_len[IDX_W'(j)]   <= r_len[IDX_W'(j - 1)];
                    r_kv[IDX_W'(j)]    <= r_kv[IDX_W'(j - 1)];
                end
            end
            r_start[r_idx[IDX_W-1:0]] <= r_cmd.start;
            r_len[r_idx[IDX_W-1:0]]   <= r_cmd.len;
            r_kv[r_idx[IDX_W-1:0]]    <= {r_cmd.key, r_cmd.vel};
        end else if ((r_state == S_REM) && (r_idx < r_total) &&
                     !((n_s == r_cmd.start) && (n_kv[13:7] == r_cmd.key))) begin
            r_start[r_w[IDX_W-1:0]] <= n_s;
            r_len[r_w[IDX_W-1:0]]   <= n_l;
            r_kv[r_w[IDX_W-1:0]]    <= n_kv;
        end
    end

endmodule

>>> src/sorted_note_event_scheduler.sv
`timescale 1ns / 1ps
// Add walks the stored notes up to the insert point and gives a full beat
// without a walk when the table is full. Remove walks every stored note.
// Tick takes two table steps per note and window part; beats leave one per
// cycle at most and cannot be held off.
// Two commands can wait in the queue between the front and the table walker.
// Reset is synchronous: the table empties and the loop length becomes zero.
// ----------------------------------------------------------------------------
// Sorted note event scheduler
// Sorted note table with insert, remove and window scan commands.
// ----------------------------------------------------------------------------
module sorted_note_event_scheduler import snes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_start_tick,
    input  logic [31:0] i_length_ticks,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_window_from,
    input  logic [31:0] i_window_to,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [2:0]  o_event_kind,
    output logic [6:0]  o_event_note,
    output logic [6:0]  o_event_velocity,
    output logic [5:0]  o_stored_notes,
    output logic        o_last
);

`include "sorted_note_event_scheduler_assert.svh"

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    snes_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_start_tick   (i_start_tick),
        .i_length_ticks (i_length_ticks),
        .i_note_number  (i_note_number),
        .i_velocity     (i_velocity),
        .i_window_from  (i_window_from),
        .i_window_to    (i_window_to),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_q_valid      (q_valid),
        .o_q_cmd        (q_cmd),
        .i_q_pop        (q_pop)
    );

    snes_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_strobe         (o_strobe),
        .o_event_kind     (o_event_kind),
        .o_event_note     (o_event_note),
        .o_event_velocity (o_event_velocity),
        .o_stored_notes   (o_stored_notes),
        .o_last           (o_last)
    );

    `SNES_ASSERT_IMP(a_total_max, o_strobe, o_stored_notes <= 6'(MAX_NOTES))
    `SNES_ASSERT_IMP(a_full_beat, o_strobe && (o_event_kind == KIND_FULL),
        (o_stored_notes == 6'(MAX_NOTES)) && o_last)
    `SNES_ASSERT_IMP(a_cmd_beat, o_strobe && (o_event_kind == KIND_ADD_OK ||
        o_event_kind == KIND_REM), o_last && (o_event_note == 7'd0))
    `SNES_ASSERT_NEVER(a_kind_range, o_strobe && (o_event_kind > KIND_OFF))

endmodule
